@@ rtl/core/slcd_pkg.sv @@
// Shared constants and types for the sync/length/CRC-16 deframer.
`default_nettype none
package slcd_pkg;

    // Sync pair and CRC-16/CCITT-FALSE constants
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 32;
    localparam int STAT_W = 2;

    // Default payload buffer size
    localparam int MAX_PAYLOAD_DEF = 64;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DATA = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CRC  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LEN  = 2'd2;

    // Command to the bit-serial CRC unit
    typedef struct packed {
        logic start;
        logic restart;
    } t_crc_cmd;

    // Address bits needed for a buffer of the given depth
    function automatic int addr_bits(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/slcd_crc_serial.sv @@
// Bit-serial CRC-16/CCITT-FALSE unit, one bit per cycle, holds the running check.
`default_nettype none
module slcd_crc_serial
    import slcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_crc_cmd          i_cmd,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_busy,
    output logic [15:0]            o_crc
);

    logic [15:0]       r_crc;
    logic [BYTE_W-1:0] r_shift;
    logic [2:0]        r_bit;
    logic              r_busy;
    logic              w_fb;

    // Feedback bit: top of the check against the next message bit
    assign w_fb = r_crc[15] ^ r_shift[BYTE_W-1];

    // Load a byte, then fold in one bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_bit  <= '0;
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            if (i_cmd.restart) begin
                r_crc <= CRC_INIT;
            end
            r_bit  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc <= {r_crc[14:0], 1'b0} ^ (w_fb ? CRC_POLY : 16'h0000);
            r_bit <= r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Message byte shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_shift <= i_byte;
        end else if (r_busy) begin
            r_shift <= {r_shift[BYTE_W-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

endmodule
`default_nettype wire

@@ rtl/core/slcd_payload_buf.sv @@
// Payload byte buffer: one write port, one registered read port.
`default_nettype none
module slcd_payload_buf
    import slcd_pkg::*;
#(
    parameter int DEPTH = MAX_PAYLOAD_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [addr_bits(DEPTH)-1:0] i_wr_addr,
    input  wire logic [BYTE_W-1:0]           i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [addr_bits(DEPTH)-1:0] i_rd_addr,
    output logic [BYTE_W-1:0]                o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Write a received payload byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/core/sync_length_crc16_deframer.sv @@
// Top level: sync hunt, length check, CRC-16 check and payload emission.
// Sync and CRC bytes are parsed in the EXEC state; a valid length byte and payload bytes also wait
// in ST_CRC while the bit-serial CRC folds them in (8 steps). A new byte stalls until the sequencer
// is idle. Each result of a valid frame takes a registered buffer read, then an output load that
// waits while the output is stalled. A byte is taken while an earlier result still waits in the output register.
// Reset: synchronous, active low; clears parser, counters and output valid, no clearing pass.
`default_nettype none
module sync_length_crc16_deframer
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [STAT_W-1:0]      o_status,
    output logic [BYTE_W-1:0]      o_data_byte,
    output logic [IDX_W-1:0]       o_byte_index,
    output logic                   o_last_byte,
    output logic [LEN_W-1:0]       o_frame_length,
    output logic [CNT_W-1:0]       o_crc_error_total,
    output logic [CNT_W-1:0]       o_length_error_total,
    output logic [CNT_W-1:0]       o_good_frame_total,
    output logic                   o_link_seen
);

    localparam int AW = addr_bits(MAX_PAYLOAD_BYTES);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_CRC  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    // Parse phases
    localparam logic [2:0] PH_SYNC0 = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_PAY   = 3'd3;
    localparam logic [2:0] PH_CRCLO = 3'd4;
    localparam logic [2:0] PH_CRCHI = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_exp_len, n_exp_len;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_emit_idx, n_emit_idx;
    logic [BYTE_W-1:0] r_rcv_lo, n_rcv_lo;
    logic [CNT_W-1:0]  r_crc_cnt, n_crc_cnt;
    logic [CNT_W-1:0]  r_len_cnt, n_len_cnt;
    logic [CNT_W-1:0]  r_ok_cnt, n_ok_cnt;
    logic              r_seen, n_seen;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;
    logic [LEN_W-1:0]  r_out_flen, n_out_flen;
    logic [CNT_W-1:0]  r_out_crc_cnt;
    logic [CNT_W-1:0]  r_out_len_cnt;
    logic [CNT_W-1:0]  r_out_ok_cnt;
    logic              r_out_seen;
    logic              w_out_load;

    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_last;
    t_crc_cmd          w_crc_cmd;
    logic              w_crc_busy;
    logic [15:0]       w_crc;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [BYTE_W-1:0] w_rd_data;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last     = ((r_emit_idx + LEN_W'(1)) == r_exp_len);

    // Bit-serial running check
    slcd_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_crc_cmd),
        .i_byte  (r_byte),
        .o_busy  (w_crc_busy),
        .o_crc   (w_crc)
    );

    // Payload buffer
    slcd_payload_buf #(
        .DEPTH (MAX_PAYLOAD_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (r_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_emit_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Sequencer and parser
    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_exp_len     = r_exp_len;
        n_fill        = r_fill;
        n_emit_idx    = r_emit_idx;
        n_rcv_lo      = r_rcv_lo;
        n_crc_cnt     = r_crc_cnt;
        n_len_cnt     = r_len_cnt;
        n_ok_cnt      = r_ok_cnt;
        n_seen        = r_seen;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = STAT_DATA;
        n_out_data    = '0;
        n_out_idx     = '0;
        n_out_last    = 1'b1;
        n_out_flen    = '0;
        w_out_load    = 1'b0;
        w_crc_cmd     = '0;
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_phase)
                    PH_SYNC1: begin
                        n_state = ST_IDLE;
                        if (r_byte == SYNC_SECOND) begin
                            n_phase = PH_LEN;
                        end else if (r_byte != SYNC_FIRST) begin
                            n_phase = PH_SYNC0;
                        end
                    end
                    PH_LEN: begin
                        if (r_byte == '0 || r_byte > BYTE_W'(MAX_PAYLOAD_BYTES)) begin
                            // drop the frame, report a bad length
                            if (w_out_free) begin
                                n_len_cnt    = r_len_cnt + CNT_W'(1);
                                n_out_status = STAT_LEN;
                                w_out_load   = 1'b1;
                                n_phase      = PH_SYNC0;
                                n_state      = ST_IDLE;
                            end
                        end else begin
                            n_exp_len         = r_byte[LEN_W-1:0];
                            n_fill            = '0;
                            w_crc_cmd.start   = 1'b1;
                            w_crc_cmd.restart = 1'b1;
                            n_phase           = PH_PAY;
                            n_state           = ST_CRC;
                        end
                    end
                    PH_PAY: begin
                        w_wr_en         = 1'b1;
                        w_crc_cmd.start = 1'b1;
                        n_fill          = r_fill + LEN_W'(1);
                        if (n_fill >= r_exp_len) begin
                            n_phase = PH_CRCLO;
                        end
                        n_state = ST_CRC;
                    end
                    PH_CRCLO: begin
                        n_rcv_lo = r_byte;
                        n_phase  = PH_CRCHI;
                        n_state  = ST_IDLE;
                    end
                    PH_CRCHI: begin
                        if ({r_byte, r_rcv_lo} != w_crc) begin
                            // report a check mismatch
                            if (w_out_free) begin
                                n_crc_cnt    = r_crc_cnt + CNT_W'(1);
                                n_out_status = STAT_CRC;
                                w_out_load   = 1'b1;
                                n_phase      = PH_SYNC0;
                                n_state      = ST_IDLE;
                            end
                        end else begin
                            n_ok_cnt   = r_ok_cnt + CNT_W'(1);
                            n_seen     = 1'b1;
                            n_emit_idx = '0;
                            n_phase    = PH_SYNC0;
                            n_state    = ST_RD;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                        n_phase = (r_byte == SYNC_FIRST) ? PH_SYNC1 : PH_SYNC0;
                    end
                endcase
            end
            ST_CRC: begin
                if (!w_crc_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                // emit one buffered payload byte
                if (w_out_free) begin
                    n_out_status = STAT_DATA;
                    n_out_data   = w_rd_data;
                    n_out_idx    = r_emit_idx[IDX_W-1:0];
                    n_out_last   = w_last;
                    n_out_flen   = r_exp_len;
                    w_out_load   = 1'b1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + LEN_W'(1);
                        n_state    = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SYNC0;
            r_exp_len   <= '0;
            r_fill      <= '0;
            r_emit_idx  <= '0;
            r_rcv_lo    <= '0;
            r_crc_cnt   <= '0;
            r_len_cnt   <= '0;
            r_ok_cnt    <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_exp_len   <= n_exp_len;
            r_fill      <= n_fill;
            r_emit_idx  <= n_emit_idx;
            r_rcv_lo    <= n_rcv_lo;
            r_crc_cnt   <= n_crc_cnt;
            r_len_cnt   <= n_len_cnt;
            r_ok_cnt    <= n_ok_cnt;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the accepted byte
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_byte <= i_rx_byte;
        end
    end

    // Output register, counters snapshot with each result
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status  <= n_out_status;
            r_out_data    <= n_out_data;
            r_out_idx     <= n_out_idx;
            r_out_last    <= n_out_last;
            r_out_flen    <= n_out_flen;
            r_out_crc_cnt <= n_crc_cnt;
            r_out_len_cnt <= n_len_cnt;
            r_out_ok_cnt  <= n_ok_cnt;
            r_out_seen    <= n_seen;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_data_byte          = r_out_data;
    assign o_byte_index         = r_out_idx;
    assign o_last_byte          = r_out_last;
    assign o_frame_length       = r_out_flen;
    assign o_crc_error_total    = r_out_crc_cnt;
    assign o_length_error_total = r_out_len_cnt;
    assign o_good_frame_total   = r_out_ok_cnt;
    assign o_link_seen          = r_out_seen;

    // Fill index stays below the expected length while collecting payload
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_fill < r_exp_len))
        else $error("fill index reached expected length in payload phase");

    // Leave the CRC wait once the serial unit is done
    a_crc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRC && !w_crc_busy) |=> (r_state == ST_IDLE))
        else $error("sequencer stuck after CRC step");

    // A data result sits inside a frame of nonzero length
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STAT_DATA) |->
            (r_out_flen != '0 && LEN_W'(r_out_idx) < r_out_flen))
        else $error("payload result index outside frame length");

    // A bad length count step comes with a bad length result
    a_len_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_cnt != $past(r_len_cnt)) |->
            (r_out_valid && r_out_status == STAT_LEN))
        else $error("length error counted without a result");

endmodule
`default_nettype wire
